### design/pointing_ray_plane_target_defines.svh
// Assertion macros shared by the pointing ray plane target RTL
`ifndef POINTING_RAY_PLANE_TARGET_DEFINES_SVH
`define POINTING_RAY_PLANE_TARGET_DEFINES_SVH
`ifndef SYNTHESIS
`define PRT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("prt assertion failed");
`define PRT_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("prt assertion failed");
`else
`define PRT_ASSERT(lbl, prop)
`define PRT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### design/prt_pkg.sv
// Shared widths, register codes, entry type and the CORDIC angle table
package prt_pkg;
   localparam int POS_W     = 24;
   localparam int QUAT_W    = 16;
   localparam int HEAD_W    = 16;
   localparam int PROD_W    = 32;
   localparam int HGT_W     = 25;
   localparam int DIR_W     = 34;
   localparam int NUM_W     = 59;
   localparam int REM_W     = 60;
   localparam int QUO_STEPS = 26;
   localparam int CX_W      = 44;
   localparam int ANG_W     = 28;
   localparam int ATAN_W    = 24;
   localparam int ATAN_LEN  = 24;
   localparam int CSR_IDX_W = 2;
   localparam int QUEUE_DEPTH_DEF  = 4;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int HEAD_MAX  = 25736;

   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_HEIGHT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INVALID_X    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVALID_Y    = 2'd2;

   localparam logic signed [POS_W-1:0] PLANE_HEIGHT_RST = 24'sd20480;
   localparam logic signed [POS_W-1:0] INVALID_X_RST    = 24'sd204800;
   localparam logic signed [POS_W-1:0] INVALID_Y_RST    = 24'sd204800;

   localparam logic signed [DIR_W-1:0] ONE_Q28 = 34'sd268435456;
   localparam logic signed [ANG_W-1:0] PI_Q24  = 28'sd52707179;

   // one classified pose between front and back
   typedef struct packed {
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic signed [HGT_W-1:0] h;
      logic signed [DIR_W-1:0] dx;
      logic signed [DIR_W-1:0] dy;
      logic signed [DIR_W-1:0] dz;
      logic                    dn;
   } qentry_type;

   function automatic logic [ATAN_W-1:0] cordic_atan(input int unsigned idx);
      logic [ATAN_W-1:0] v;
      case (idx)
         0:  v = 24'd13176795;
         1:  v = 24'd7778716;
         2:  v = 24'd4110060;
         3:  v = 24'd2086331;
         4:  v = 24'd1047214;
         5:  v = 24'd524117;
         6:  v = 24'd262123;
         7:  v = 24'd131069;
         8:  v = 24'd65536;
         9:  v = 24'd32768;
         10: v = 24'd16384;
         11: v = 24'd8192;
         12: v = 24'd4096;
         13: v = 24'd2048;
         14: v = 24'd1024;
         15: v = 24'd512;
         16: v = 24'd256;
         17: v = 24'd128;
         18: v = 24'd64;
         19: v = 24'd32;
         20: v = 24'd16;
         21: v = 24'd8;
         22: v = 24'd4;
         23: v = 24'd2;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage

### design/prt_req_if.sv
// Pose request channel: valid, ready and the pose beat
interface prt_req_if
   import prt_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  pos_x;
   logic signed [POS_W-1:0]  pos_y;
   logic signed [POS_W-1:0]  pos_z;
   logic signed [QUAT_W-1:0] quat_x;
   logic signed [QUAT_W-1:0] quat_y;
   logic signed [QUAT_W-1:0] quat_z;
   logic signed [QUAT_W-1:0] quat_w;

   modport source (output valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
                   input ready);
   modport sink (input valid, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
                 output ready);
endinterface

### design/prt_rsp_if.sv
// Target response channel: valid, ready and the target beat
interface prt_rsp_if
   import prt_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [POS_W-1:0]  target_x;
   logic signed [POS_W-1:0]  target_y;
   logic signed [HEAD_W-1:0] heading;
   logic                     target_valid;

   modport source (output valid, target_x, target_y, heading, target_valid, input ready);
   modport sink (input valid, target_x, target_y, heading, target_valid, output ready);
endinterface

### design/prt_front.sv
// Front end: accept poses, form the pointing direction and classify it
module prt_front
   import prt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   prt_req_if.sink                 req,
   input  logic signed [POS_W-1:0] plane_height,
   input  logic                    q_full,
   output logic                    push,
   output qentry_type              push_data
);
   logic                     en;
   logic                     f1_vld_ff, f1_vld_in, f2_vld_ff, f2_vld_in;
   logic signed [PROD_W-1:0] yy_ff, zz_ff, xy_ff, zw_ff, xz_ff, yw_ff;
   logic signed [PROD_W-1:0] yy_in, zz_in, xy_in, zw_in, xz_in, yw_in;
   logic signed [POS_W-1:0]  px1_ff, py1_ff;
   logic signed [HGT_W-1:0]  h1_ff, h1_in;
   qentry_type               ent_ff, ent_in;
   logic signed [DIR_W-1:0]  s_yz, s_xy, s_xz;

   // advance unless a finished beat is blocked by a full queue
   assign en        = !f2_vld_ff || !q_full;
   assign req.ready = en;
   assign push      = f2_vld_ff && !q_full;
   assign push_data = ent_ff;

   assign f1_vld_in = en ? req.valid : f1_vld_ff;
   assign f2_vld_in = en ? f1_vld_ff : f2_vld_ff;

   // quaternion products and plane offset
   always_comb begin
      yy_in = PROD_W'(req.quat_y) * PROD_W'(req.quat_y);
      zz_in = PROD_W'(req.quat_z) * PROD_W'(req.quat_z);
      xy_in = PROD_W'(req.quat_x) * PROD_W'(req.quat_y);
      zw_in = PROD_W'(req.quat_z) * PROD_W'(req.quat_w);
      xz_in = PROD_W'(req.quat_x) * PROD_W'(req.quat_z);
      yw_in = PROD_W'(req.quat_y) * PROD_W'(req.quat_w);
      h1_in = HGT_W'(plane_height) - HGT_W'(req.pos_z);
   end

   // direction sums and downward test
   always_comb begin
      s_yz = DIR_W'(yy_ff) + DIR_W'(zz_ff);
      s_xy = DIR_W'(xy_ff) + DIR_W'(zw_ff);
      s_xz = DIR_W'(xz_ff) - DIR_W'(yw_ff);
      ent_in.px = px1_ff;
      ent_in.py = py1_ff;
      ent_in.h  = h1_ff;
      ent_in.dx = ONE_Q28 - (s_yz <<< 1);
      ent_in.dy = s_xy <<< 1;
      ent_in.dz = s_xz <<< 1;
      ent_in.dn = s_xz[DIR_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else begin
         f1_vld_ff <= f1_vld_in;
         f2_vld_ff <= f2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         yy_ff  <= yy_in;
         zz_ff  <= zz_in;
         xy_ff  <= xy_in;
         zw_ff  <= zw_in;
         xz_ff  <= xz_in;
         yw_ff  <= yw_in;
         px1_ff <= req.pos_x;
         py1_ff <= req.pos_y;
         h1_ff  <= h1_in;
         ent_ff <= ent_in;
      end
   end
endmodule

### design/prt_queue.sv
// Short queue that decouples the front end from the back end
module prt_queue
   import prt_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  qentry_type push_data,
   output logic       full,
   input  logic       pop,
   output qentry_type pop_data,
   output logic       empty
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   qentry_type       mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   // advance pointers with wrap at the depth
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

`include "pointing_ray_plane_target_defines.svh"
   `PRT_ASSERT(a_no_overflow, push |-> !full)
   `PRT_ASSERT(a_no_underflow, pop |-> !empty)
   `PRT_ASSERT(a_cnt_range, cnt_ff <= CNT_W'(DEPTH))
   `PRT_ASSERT(a_cnt_track, (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
endmodule

### design/prt_back.sv
// Back end: divide for the plane hit, saturate, run CORDIC atan2, drive the response
module prt_back
   import prt_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  qentry_type              q_data,
   output logic                    pop,
   input  logic signed [POS_W-1:0] invalid_x,
   input  logic signed [POS_W-1:0] invalid_y,
   prt_rsp_if.source               rsp
);
   // stage positions in the valid line
   localparam int B0_STG  = 0;
   localparam int B1_STG  = 1;
   localparam int DV_STG  = 2;
   localparam int T_STG   = DV_STG + QUO_STEPS + 1;
   localparam int CR_STG  = T_STG + 1;
   localparam int OUT_STG = CR_STG + CORDIC_STEPS + 1;
   localparam int NSTG    = OUT_STG + 1;
   localparam int QM_W    = QUO_STEPS + 1;
   localparam int SUM_W   = POS_W + 4;
   localparam int RND_W   = ANG_W - 11;

   localparam logic signed [SUM_W-1:0] S24_MAX = SUM_W'((1 << (POS_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] S24_MIN = -SUM_W'(1 << (POS_W - 1));
   localparam logic [QM_W-1:0] QSAT = QM_W'(1) << (QUO_STEPS - 1);

   typedef struct packed {
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic                    dn;
      logic signed [NUM_W-1:0] nx;
      logic signed [NUM_W-1:0] ny;
      logic signed [DIR_W-1:0] dz;
   } mul_type;

   typedef struct packed {
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic                    dn;
      logic [NUM_W-1:0]        ax;
      logic [NUM_W-1:0]        ay;
      logic [DIR_W-1:0]        den;
      logic                    negx;
      logic                    negy;
   } abs_type;

   typedef struct packed {
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic                    dn;
      logic [REM_W-1:0]        remx;
      logic [REM_W-1:0]        remy;
      logic [DIR_W-1:0]        den;
      logic                    negx;
      logic                    negy;
      logic [QUO_STEPS-1:0]    qx;
      logic [QUO_STEPS-1:0]    qy;
   } div_type;

   typedef struct packed {
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic signed [POS_W-1:0] tx;
      logic signed [POS_W-1:0] ty;
      logic                    dn;
   } tgt_type;

   typedef struct packed {
      logic signed [POS_W-1:0] tx;
      logic signed [POS_W-1:0] ty;
      logic                    dn;
      logic                    zero;
      logic signed [CX_W-1:0]  cx;
      logic signed [CX_W-1:0]  cy;
      logic signed [ANG_W-1:0] ang;
   } cr_type;

   // one restoring step: try the divisor shifted by s on both quotients
   function automatic div_type div_step(input div_type d, input int unsigned s);
      div_type          r;
      logic [REM_W-1:0] sh;
      logic             gex, gey;
      r   = d;
      sh  = REM_W'(d.den) << s;
      gex = d.remx >= sh;
      gey = d.remy >= sh;
      if (gex) begin
         r.remx = d.remx - sh;
      end
      if (gey) begin
         r.remy = d.remy - sh;
      end
      r.qx = {d.qx[QUO_STEPS-2:0], gex};
      r.qy = {d.qy[QUO_STEPS-2:0], gey};
      return r;
   endfunction

   // one vectoring rotation by the i-th table angle
   function automatic cr_type cordic_step(input cr_type c, input int unsigned i);
      cr_type                  r;
      logic signed [CX_W-1:0]  xs, ys;
      logic signed [ANG_W-1:0] at;
      r  = c;
      xs = c.cx >>> i;
      ys = c.cy >>> i;
      at = ANG_W'(cordic_atan(i));
      if (c.cy > 0) begin
         r.cx  = c.cx + ys;
         r.cy  = c.cy - xs;
         r.ang = c.ang + at;
      end else begin
         r.cx  = c.cx - ys;
         r.cy  = c.cy + xs;
         r.ang = c.ang - at;
      end
      return r;
   endfunction

   // saturate a signed quotient magnitude and add it to the hand position
   function automatic logic signed [POS_W-1:0] place(input logic signed [POS_W-1:0] p,
                                                   input logic [QUO_STEPS-1:0] q,
                                                   input logic neg);
      logic [QM_W-1:0]         mag;
      logic signed [QM_W-1:0]  qs;
      logic signed [SUM_W-1:0] sum;
      logic signed [POS_W-1:0] res;
      mag = q[QUO_STEPS-1] ? QSAT : {2'b00, q[QUO_STEPS-2:0]};
      qs  = neg ? -$signed(mag) : $signed(mag);
      sum = SUM_W'(p) + SUM_W'(qs);
      if (sum > S24_MAX) begin
         res = S24_MAX[POS_W-1:0];
      end else if (sum < S24_MIN) begin
         res = S24_MIN[POS_W-1:0];
      end else begin
         res = sum[POS_W-1:0];
      end
      return res;
   endfunction

   logic                    en;
   logic [NSTG-1:0]         vld_ff, vld_in;
   mul_type                 b0_ff, b0_in;
   abs_type                 b1_ff, b1_in;
   div_type                 dv_ff [QUO_STEPS+1];
   div_type                 dv0_in;
   tgt_type                 t_ff, t_in;
   cr_type                  cr_ff [CORDIC_STEPS+1];
   cr_type                  cr0_in;
   logic signed [HGT_W-1:0] vx, vy;
   logic signed [CX_W-1:0]  x0, y0;
   logic [ANG_W-1:0]        amag;
   logic [RND_W-1:0]        rnd, hmag;
   logic signed [POS_W-1:0] otx_ff, otx_in, oty_ff, oty_in;
   logic signed [HEAD_W-1:0] ohd_ff, ohd_in;
   logic                    ovl_ff, ovl_in;

   // the whole back line moves together when the response slot can take a beat
   assign en     = !vld_ff[OUT_STG] || rsp.ready;
   assign pop    = en && !q_empty;
   assign vld_in = en ? {vld_ff[NSTG-2:0], !q_empty} : vld_ff;

   // products for both offsets
   always_comb begin
      b0_in.px = q_data.px;
      b0_in.py = q_data.py;
      b0_in.dn = q_data.dn;
      b0_in.nx = NUM_W'(q_data.h) * NUM_W'(q_data.dx);
      b0_in.ny = NUM_W'(q_data.h) * NUM_W'(q_data.dy);
      b0_in.dz = q_data.dz;
   end

   // magnitudes and quotient signs; the divisor is negative on valid beats
   always_comb begin
      b1_in.px   = b0_ff.px;
      b1_in.py   = b0_ff.py;
      b1_in.dn   = b0_ff.dn;
      b1_in.ax   = b0_ff.nx[NUM_W-1] ? NUM_W'(-b0_ff.nx) : NUM_W'(b0_ff.nx);
      b1_in.ay   = b0_ff.ny[NUM_W-1] ? NUM_W'(-b0_ff.ny) : NUM_W'(b0_ff.ny);
      b1_in.den  = DIR_W'(-b0_ff.dz);
      b1_in.negx = !b0_ff.nx[NUM_W-1];
      b1_in.negy = !b0_ff.ny[NUM_W-1];
   end

   // add half the divisor for round to nearest
   always_comb begin
      dv0_in.px   = b1_ff.px;
      dv0_in.py   = b1_ff.py;
      dv0_in.dn   = b1_ff.dn;
      dv0_in.remx = REM_W'(b1_ff.ax) + REM_W'(b1_ff.den >> 1);
      dv0_in.remy = REM_W'(b1_ff.ay) + REM_W'(b1_ff.den >> 1);
      dv0_in.den  = b1_ff.den;
      dv0_in.negx = b1_ff.negx;
      dv0_in.negy = b1_ff.negy;
      dv0_in.qx   = '0;
      dv0_in.qy   = '0;
   end

   // saturated targets
   always_comb begin
      t_in.px = dv_ff[QUO_STEPS].px;
      t_in.py = dv_ff[QUO_STEPS].py;
      t_in.dn = dv_ff[QUO_STEPS].dn;
      t_in.tx = place(dv_ff[QUO_STEPS].px, dv_ff[QUO_STEPS].qx, dv_ff[QUO_STEPS].negx);
      t_in.ty = place(dv_ff[QUO_STEPS].py, dv_ff[QUO_STEPS].qy, dv_ff[QUO_STEPS].negy);
   end

   // heading vector, scaled, turned by pi when it points to negative x
   always_comb begin
      vx         = HGT_W'(t_ff.tx) - HGT_W'(t_ff.px);
      vy         = HGT_W'(t_ff.ty) - HGT_W'(t_ff.py);
      x0         = CX_W'(vx) <<< 16;
      y0         = CX_W'(vy) <<< 16;
      cr0_in.tx  = t_ff.tx;
      cr0_in.ty  = t_ff.ty;
      cr0_in.dn  = t_ff.dn;
      cr0_in.zero = (vx == '0) && (vy == '0);
      if (x0 < 0) begin
         cr0_in.cx  = -x0;
         cr0_in.cy  = -y0;
         cr0_in.ang = (y0 >= 0) ? PI_Q24 : -PI_Q24;
      end else begin
         cr0_in.cx  = x0;
         cr0_in.cy  = y0;
         cr0_in.ang = '0;
      end
   end

   // round the angle to Q3.13, clamp, and pick the response fields
   always_comb begin
      amag = cr_ff[CORDIC_STEPS].ang[ANG_W-1] ? ANG_W'(-cr_ff[CORDIC_STEPS].ang)
                                              : ANG_W'(cr_ff[CORDIC_STEPS].ang);
      rnd  = RND_W'((amag + ANG_W'(1024)) >> 11);
      hmag = (rnd > RND_W'(HEAD_MAX)) ? RND_W'(HEAD_MAX) : rnd;
      if (!cr_ff[CORDIC_STEPS].dn) begin
         otx_in = invalid_x;
         oty_in = invalid_y;
         ohd_in = '0;
         ovl_in = 1'b0;
      end else begin
         otx_in = cr_ff[CORDIC_STEPS].tx;
         oty_in = cr_ff[CORDIC_STEPS].ty;
         ovl_in = 1'b1;
         if (cr_ff[CORDIC_STEPS].zero) begin
            ohd_in = '0;
         end else if (cr_ff[CORDIC_STEPS].ang[ANG_W-1]) begin
            ohd_in = -HEAD_W'(hmag);
         end else begin
            ohd_in = HEAD_W'(hmag);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b0_ff    <= b0_in;
         b1_ff    <= b1_in;
         dv_ff[0] <= dv0_in;
         for (int k = 0; k < QUO_STEPS; k++) begin
            dv_ff[k+1] <= div_step(dv_ff[k], QUO_STEPS - 1 - k);
         end
         t_ff     <= t_in;
         cr_ff[0] <= cr0_in;
         for (int j = 0; j < CORDIC_STEPS; j++) begin
            cr_ff[j+1] <= cordic_step(cr_ff[j], j);
         end
         otx_ff   <= otx_in;
         oty_ff   <= oty_in;
         ohd_ff   <= ohd_in;
         ovl_ff   <= ovl_in;
      end
   end

   assign rsp.valid        = vld_ff[OUT_STG];
   assign rsp.target_x     = otx_ff;
   assign rsp.target_y     = oty_ff;
   assign rsp.heading      = ohd_ff;
   assign rsp.target_valid = ovl_ff;

`include "pointing_ray_plane_target_defines.svh"
   `PRT_ASSERT(a_head_range, vld_ff[OUT_STG] |-> (ohd_ff <= 16'sd25736 && ohd_ff >= -16'sd25736))
   `PRT_ASSERT(a_invalid_zero, (vld_ff[OUT_STG] && !ovl_ff) |-> ohd_ff == '0)
   `PRT_ASSERT(a_hold_stall, (vld_ff[OUT_STG] && !en) |=> $stable(vld_ff) && $stable(ohd_ff))
endmodule

### design/pointing_ray_plane_target.sv
// Top level: configuration registers, front end, queue and back end
//
//  channel   dir  handshake          beat
//  req_chan  in   valid/ready        pos_x/y/z, quat_x/y/z/w
//  rsp_chan  out  valid/ready        target_x/y, heading, target_valid
//  csr_*     in   csr_we write only  csr_idx selects register, csr_wdata value
//
// One pose is taken per cycle unless a full queue holds the front end; each gives
// one response through the front registers, queue and back line (26 divider steps,
// CORDIC stages); the divider and CORDIC are pipelined, so poses overlap in them.
// Reset clears all valid state and loads register defaults; no clearing pass.
// A stalled response freezes the back end; the queue lets the front take poses until full.
module pointing_ray_plane_target
   import prt_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   prt_req_if.sink              req_chan,
   prt_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_idx,
   input  logic [POS_W-1:0]     csr_wdata
);
   logic signed [POS_W-1:0] plane_height_ff, plane_height_in;
   logic signed [POS_W-1:0] invalid_x_ff, invalid_x_in;
   logic signed [POS_W-1:0] invalid_y_ff, invalid_y_in;
   logic       push, pop, q_full, q_empty;
   qentry_type push_data, pop_data;

   // decode register writes; unknown indexes drop
   always_comb begin
      plane_height_in = plane_height_ff;
      invalid_x_in    = invalid_x_ff;
      invalid_y_in    = invalid_y_ff;
      if (csr_we) begin
         unique case (csr_idx)
            CSR_PLANE_HEIGHT: plane_height_in = $signed(csr_wdata);
            CSR_INVALID_X:    invalid_x_in    = $signed(csr_wdata);
            CSR_INVALID_Y:    invalid_y_in    = $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_height_ff <= PLANE_HEIGHT_RST;
         invalid_x_ff    <= INVALID_X_RST;
         invalid_y_ff    <= INVALID_Y_RST;
      end else begin
         plane_height_ff <= plane_height_in;
         invalid_x_ff    <= invalid_x_in;
         invalid_y_ff    <= invalid_y_in;
      end
   end

   prt_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .plane_height (plane_height_ff),
      .q_full       (q_full),
      .push         (push),
      .push_data    (push_data)
   );

   prt_queue #(.DEPTH(QUEUE_DEPTH_DEF)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   prt_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (pop_data),
      .pop       (pop),
      .invalid_x (invalid_x_ff),
      .invalid_y (invalid_y_ff),
      .rsp       (rsp_chan)
   );
endmodule

### tb/sv/pointing_ray_plane_target_test.sv
// Self-checking test of the pointing ray plane target block with a built-in target predictor
module pointing_ray_plane_target_test;
   import prt_pkg::*;

   localparam int STEPS      = CORDIC_STEPS_DEF;
   localparam int IDLE_LIMIT = 3000;
   localparam int DRAIN_WAIT = 80;
   localparam int PHASE_LEN  = 500;
   localparam int HOLD_START = 2500;
   localparam int HOLD_LEN   = 400;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic signed [POS_W-1:0]  px, py, pz;
      logic signed [QUAT_W-1:0] qx, qy, qz, qw;
   } pose_type;

   typedef struct {
      logic signed [POS_W-1:0]  tx, ty;
      logic signed [HEAD_W-1:0] hd;
      logic                     ok;
   } target_type;

   typedef struct {
      pose_type   pose;
      bit         typed;
      target_type want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_idx = '0;
   logic [POS_W-1:0] csr_wdata = '0;

   prt_req_if req_chan ();
   prt_rsp_if rsp_chan ();

   pointing_ray_plane_target #(.CORDIC_STEPS(STEPS)) dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_idx(csr_idx), .csr_wdata(csr_wdata)
   );

   // predictor copy of the registers
   longint plane_h = 20480;
   longint miss_x  = 204800;
   longint miss_y  = 204800;

   target_type target_q[$];
   row_type    typed_q[$];
   bit         typed_next = 0;
   int         errors = 0;
   int         idle_cycles = 0;

   longint arc_tab[24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
      131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8,
      4, 2};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // quotient rounded to nearest, ties away from zero
   function automatic longint quo_round(longint n, longint d);
      longint unsigned un, ud, q;
      un = n < 0 ? -n : n;
      ud = d < 0 ? -d : d;
      q = (un + ud / 2) / ud;
      return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
   endfunction

   // vectoring CORDIC atan2, result in Q3.13
   function automatic longint aim_angle(longint vx, longint vy);
      longint x, y, ang, xs, ys;
      longint unsigned ua;
      x = vx * 65536;
      y = vy * 65536;
      ang = 0;
      if (vx == 0 && vy == 0) return 0;
      if (x < 0) begin
         ang = (y >= 0) ? 52707179 : -52707179;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; ang += arc_tab[i];
         end else begin
            x -= ys; y += xs; ang -= arc_tab[i];
         end
      end
      ua = ang < 0 ? -ang : ang;
      ua = (ua + 1024) >> 11;
      return sat(ang < 0 ? -longint'(ua) : longint'(ua), -HEAD_MAX, HEAD_MAX);
   endfunction

   function automatic target_type aim_target(pose_type p);
      target_type t;
      longint qx, qy, qz, qw, dx, dy, dz, h, tx, ty;
      qx = longint'(p.qx); qy = longint'(p.qy); qz = longint'(p.qz); qw = longint'(p.qw);
      dx = (longint'(1) << 28) - 2 * (qy * qy + qz * qz);
      dy = 2 * (qx * qy + qz * qw);
      dz = 2 * (qx * qz - qy * qw);
      if (dz >= 0) begin
         t.tx = POS_W'(miss_x); t.ty = POS_W'(miss_y); t.hd = '0; t.ok = 1'b0;
      end else begin
         h = plane_h - longint'(p.pz);
         tx = sat(longint'(p.px) + quo_round(h * dx, dz), -8388608, 8388607);
         ty = sat(longint'(p.py) + quo_round(h * dy, dz), -8388608, 8388607);
         t.tx = POS_W'(tx); t.ty = POS_W'(ty);
         t.hd = HEAD_W'(aim_angle(tx - longint'(p.px), ty - longint'(p.py)));
         t.ok = 1'b1;
      end
      return t;
   endfunction

   task automatic report(string field, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", field, got, want);
   endtask

   // predict each accepted pose beat, check each accepted target beat
   always @(posedge clock) begin
      pose_type   p;
      target_type t, w;
      row_type    r;
      if (!reset && req_chan.valid && req_chan.ready) begin
         p = '{req_chan.pos_x, req_chan.pos_y, req_chan.pos_z,
               req_chan.quat_x, req_chan.quat_y, req_chan.quat_z, req_chan.quat_w};
         t = aim_target(p);
         if (typed_next) begin
            r = typed_q.pop_front();
            t = r.want;
         end
         target_q.push_back(t);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (target_q.size() == 0) begin
            report("unexpected beat", 0, 0);
         end else begin
            w = target_q.pop_front();
            if (rsp_chan.target_x !== w.tx) report("target_x", rsp_chan.target_x, w.tx);
            if (rsp_chan.target_y !== w.ty) report("target_y", rsp_chan.target_y, w.ty);
            if (rsp_chan.heading !== w.hd) report("heading", rsp_chan.heading, w.hd);
            if (rsp_chan.target_valid !== w.ok)
               report("target_valid", rsp_chan.target_valid, w.ok);
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("pointing_ray_plane_target_test failed");
         $finish;
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver: random gaps, and one long hold-off to back up the pipeline
   initial begin
      int cyc, gap;
      rsp_chan.ready = 1'b0;
      cyc = 0;
      gap = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc == HOLD_START) begin
            rsp_chan.ready = 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
         end
         if (gap > 0) begin
            rsp_chan.ready = 1'b0;
            gap--;
         end else begin
            rsp_chan.ready = 1'b1;
            if ($urandom_range(0, 3) == 0) gap = gap_len();
         end
      end
   end

   // offer one pose beat and hold it until taken
   task automatic send_pose(pose_type p);
      int gap;
      gap = gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.pos_x = p.px; req_chan.pos_y = p.py; req_chan.pos_z = p.pz;
      req_chan.quat_x = p.qx; req_chan.quat_y = p.qy;
      req_chan.quat_z = p.qz; req_chan.quat_w = p.qw;
      req_chan.valid = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic signed [POS_W-1:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_idx = idx;
      csr_wdata = val;
      case (idx)
         CSR_PLANE_HEIGHT: plane_h = longint'(val);
         CSR_INVALID_X:    miss_x = longint'(val);
         CSR_INVALID_Y:    miss_y = longint'(val);
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // hold until every target is back, then let the pipeline settle
   task automatic drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (target_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic signed [QUAT_W-1:0] rand_quat();
      return QUAT_W'(int'($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic pose_type rand_pose();
      pose_type p;
      if ($urandom_range(0, 1)) begin
         p.px = POS_W'(int'($urandom_range(0, 51200)) - 25600);
         p.py = POS_W'(int'($urandom_range(0, 51200)) - 25600);
         p.pz = POS_W'(int'($urandom_range(0, 51200)) - 25600);
      end else begin
         p.px = POS_W'($urandom); p.py = POS_W'($urandom); p.pz = POS_W'($urandom);
      end
      p.qx = rand_quat(); p.qy = rand_quat(); p.qz = rand_quat(); p.qw = rand_quat();
      // mostly near-unit poses tipped downward
      if ($urandom_range(0, 9) < 6) begin
         p.qx = p.qx >>> 2; p.qz = p.qz >>> 2;
         p.qy = QUAT_W'(11585 + (int'($urandom_range(0, 4000)) - 2000));
         p.qw = QUAT_W'(11585 + (int'($urandom_range(0, 4000)) - 2000));
         if ($urandom_range(0, 1)) begin
            p.qy = -p.qy; p.qw = -p.qw;
         end
      end
      return p;
   endfunction

   row_type dir_tab[14] = '{
      // level and zero quaternions give the out-of-bounds target
      '{'{0, 0, 0, 0, 0, 0, 16384}, 1, '{204800, 204800, 0, 0}},
      '{'{100, -100, 5, 0, 0, 0, 0}, 1, '{204800, 204800, 0, 0}},
      // upward or level gestures
      '{'{0, 0, 0, 0, -11585, 0, 11585}, 1, '{204800, 204800, 0, 0}},
      '{'{1, 2, 3, 16384, 16384, 16384, 16384}, 1, '{204800, 204800, 0, 0}},
      '{'{1, 2, 3, 16384, -16384, 16384, 16384}, 1, '{204800, 204800, 0, 0}},
      // hand on the plane: target equals hand, heading zero
      '{'{5000, -7000, 20480, 0, 11585, 0, 11585}, 1, '{5000, -7000, 0, 1}},
      // straight down from various hands
      '{'{0, 0, 0, 0, 11585, 0, 11585}, 0, '{0, 0, 0, 0}},
      '{'{8388607, 8388607, 8388607, 0, 11585, 0, 11585}, 0, '{0, 0, 0, 0}},
      '{'{-8388608, -8388608, -8388608, 0, 11585, 0, 11585}, 0, '{0, 0, 0, 0}},
      // tilted rays, hands below and above the plane, full-scale components
      '{'{0, 0, -25600, 3000, 11000, -2000, 12000}, 0, '{0, 0, 0, 0}},
      '{'{-3000, 4000, 60000, -3000, 9000, 4000, 13000}, 0, '{0, 0, 0, 0}},
      '{'{100, 200, 300, 16384, 16384, -16384, 16384}, 0, '{0, 0, 0, 0}},
      '{'{-100, 200, -300, -16384, 16384, 16384, -16384}, 0, '{0, 0, 0, 0}},
      '{'{7, -7, 40000, 0, 16384, 0, 16384}, 0, '{0, 0, 0, 0}}
   };

   initial begin
      req_chan.valid = 1'b0;
      req_chan.pos_x = '0; req_chan.pos_y = '0; req_chan.pos_z = '0;
      req_chan.quat_x = '0; req_chan.quat_y = '0;
      req_chan.quat_z = '0; req_chan.quat_w = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows at reset settings, one at a time so typed rows line up
      foreach (dir_tab[i]) begin
         if (dir_tab[i].typed) typed_q.push_back(dir_tab[i]);
         typed_next = dir_tab[i].typed;
         send_pose(dir_tab[i].pose);
         drain();
      end
      typed_next = 0;

      for (int ph = 0; ph < 4; ph++) begin
         for (int n = 0; n < PHASE_LEN; n++) send_pose(rand_pose());
         drain();
         case (ph)
            0: begin
               csr_write(CSR_PLANE_HEIGHT, 24'sh7fffff);
               csr_write(CSR_INVALID_X, 24'sh800000);
               csr_write(CSR_INVALID_Y, 24'sh7fffff);
            end
            1: begin
               csr_write(CSR_PLANE_HEIGHT, 24'sh800000);
               csr_write(CSR_INVALID_X, 24'sh7fffff);
               csr_write(CSR_INVALID_Y, 24'sh800000);
            end
            2: begin
               csr_write(CSR_PLANE_HEIGHT, POS_W'($urandom));
               csr_write(CSR_INVALID_X, POS_W'($urandom));
               csr_write(CSR_INVALID_Y, POS_W'($urandom));
               csr_write(CSR_UNUSED, POS_W'($urandom));
            end
            default: ;
         endcase
      end

      if (errors == 0)
         $display("pointing_ray_plane_target_test passed");
      else
         $display("pointing_ray_plane_target_test failed");
      $finish;
   end
endmodule

### sim.f
+incdir+design
design/prt_pkg.sv
design/prt_req_if.sv
design/prt_rsp_if.sv
design/prt_front.sv
design/prt_queue.sv
design/prt_back.sv
design/pointing_ray_plane_target.sv
tb/sv/pointing_ray_plane_target_test.sv
